// File: rtl/core/hrht_pkg.sv
// ============================================================================
// hrht_pkg
// Shared types and constants for the HTTP request head tokenizer.
// ============================================================================
package hrht_pkg;

  // Default width of the per-field length limits.
  localparam int LIMIT_BITS_DEF = 12;

  // Reset values of the limit registers, truncated to the limit width on use.
  localparam int unsigned METHOD_LIMIT_RST  = 100;
  localparam int unsigned TARGET_LIMIT_RST  = 1000;
  localparam int unsigned VERSION_LIMIT_RST = 50;
  localparam int unsigned NAME_LIMIT_RST    = 1000;
  localparam int unsigned VALUE_LIMIT_RST   = 1000;

  // Number of limit registers and their indexes.
  localparam int NUM_LIMITS = 5;
  localparam int REG_IDX_BITS = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_METHOD_LIMIT  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_LIMIT  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_VERSION_LIMIT = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_NAME_LIMIT    = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_VALUE_LIMIT   = 3'd4;

  // Special bytes of the request syntax.
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Parser phase. Code 7 is unused and behaves as the method phase.
  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_TARGET  = 3'd1,
    PH_VERSION = 3'd2,
    PH_LINE    = 3'd3,
    PH_NAME    = 3'd4,
    PH_VALUE   = 3'd5,
    PH_BLANK   = 3'd6
  } phase_t;

  // Byte role reported with every result.
  typedef enum logic [2:0] {
    ROLE_DELIM   = 3'd0,
    ROLE_METHOD  = 3'd1,
    ROLE_TARGET  = 3'd2,
    ROLE_VERSION = 3'd3,
    ROLE_NAME    = 3'd4,
    ROLE_VALUE   = 3'd5
  } role_t;

  // Per-byte classification produced by the step logic.
  typedef struct packed {
    role_t role;
    logic  field_done;
    logic  request_done;
    logic  request_error;
  } result_t;

endpackage

// File: rtl/core/http_request_head_tokenizer_core.sv
// ============================================================================
// http_request_head_tokenizer_core
// Labels each byte of an HTTP request head with its role and field events.
// ============================================================================
//
//  Channel | Direction | Transaction payload
//  --------+-----------+------------------------------------------------------
//  in_     | sink      | one received request byte
//  out_    | source    | tdata: the byte; tuser: role, field_done,
//          |           | request_error; tlast marks the final LF of the head
//  cfg_    | APB slave | five field length limits at byte addresses 0..16
//
// The parser state advances at the edge that accepts the byte, and its
// result is registered into the output stage, so a byte may be accepted in
// every cycle while in_tready is high.
// A two-entry output stage (output register plus skid register) keeps in_tready
// registered; it drops only when both entries hold results.
// Reset (rst_n low, synchronous) returns the parser to the method phase,
// empties the output stage and loads the default limits.
// Limit registers should only be written while no byte is in flight.
//
module http_request_head_tokenizer_core #(
  parameter int LIMIT_BITS = hrht_pkg::LIMIT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream. in_tdata: [7:0] in_byte.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // Result stream. out_tdata: [7:0] out_byte. out_tuser: [2:0] role,
  // [3] field_done, [4] request_error. out_tlast carries request_done.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic [4:0]  out_tuser,
  output logic        out_tlast,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hrht_pkg::*;

  localparam logic [LIMIT_BITS-1:0] RST_METHOD  = LIMIT_BITS'(METHOD_LIMIT_RST);
  localparam logic [LIMIT_BITS-1:0] RST_TARGET  = LIMIT_BITS'(TARGET_LIMIT_RST);
  localparam logic [LIMIT_BITS-1:0] RST_VERSION = LIMIT_BITS'(VERSION_LIMIT_RST);
  localparam logic [LIMIT_BITS-1:0] RST_NAME    = LIMIT_BITS'(NAME_LIMIT_RST);
  localparam logic [LIMIT_BITS-1:0] RST_VALUE   = LIMIT_BITS'(VALUE_LIMIT_RST);

  // Limit registers.
  logic [NUM_LIMITS-1:0][LIMIT_BITS-1:0] limits_r;
  logic [REG_IDX_BITS-1:0]               cfg_idx;
  logic                                  cfg_wr;

  // Parser state.
  phase_t              phase_r,      phase_nxt;
  logic                cr_pending_r, cr_pending_nxt;
  logic [LIMIT_BITS:0] count_r,      count_nxt;
  result_t             step_result;

  // Output stage: main register and skid register.
  logic       out_valid_r,  skid_valid_r;
  logic [7:0] out_byte_r,   skid_byte_r;
  result_t    out_result_r, skid_result_r;

  logic in_fire;
  logic out_load;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied
  // high. Indexes past the last limit are ignored.
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r[REG_METHOD_LIMIT]  <= RST_METHOD;
      limits_r[REG_TARGET_LIMIT]  <= RST_TARGET;
      limits_r[REG_VERSION_LIMIT] <= RST_VERSION;
      limits_r[REG_NAME_LIMIT]    <= RST_NAME;
      limits_r[REG_VALUE_LIMIT]   <= RST_VALUE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_METHOD_LIMIT:  limits_r[REG_METHOD_LIMIT]  <= cfg_pwdata[LIMIT_BITS-1:0];
        REG_TARGET_LIMIT:  limits_r[REG_TARGET_LIMIT]  <= cfg_pwdata[LIMIT_BITS-1:0];
        REG_VERSION_LIMIT: limits_r[REG_VERSION_LIMIT] <= cfg_pwdata[LIMIT_BITS-1:0];
        REG_NAME_LIMIT:    limits_r[REG_NAME_LIMIT]    <= cfg_pwdata[LIMIT_BITS-1:0];
        REG_VALUE_LIMIT:   limits_r[REG_VALUE_LIMIT]   <= cfg_pwdata[LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_METHOD_LIMIT:  cfg_prdata[LIMIT_BITS-1:0] = limits_r[REG_METHOD_LIMIT];
      REG_TARGET_LIMIT:  cfg_prdata[LIMIT_BITS-1:0] = limits_r[REG_TARGET_LIMIT];
      REG_VERSION_LIMIT: cfg_prdata[LIMIT_BITS-1:0] = limits_r[REG_VERSION_LIMIT];
      REG_NAME_LIMIT:    cfg_prdata[LIMIT_BITS-1:0] = limits_r[REG_NAME_LIMIT];
      REG_VALUE_LIMIT:   cfg_prdata[LIMIT_BITS-1:0] = limits_r[REG_VALUE_LIMIT];
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Parser. The step logic classifies the incoming byte against the current
  // state; the state moves on only when the byte transaction completes.
  // --------------------------------------------------------------------------
  hrht_step #(
    .LIMIT_BITS (LIMIT_BITS)
  ) u_step (
    .byte_i       (in_tdata),
    .phase_i      (phase_r),
    .cr_pending_i (cr_pending_r),
    .count_i      (count_r),
    .limits_i     (limits_r),
    .phase_o      (phase_nxt),
    .cr_pending_o (cr_pending_nxt),
    .count_o      (count_nxt),
    .result_o     (step_result)
  );

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_METHOD;
      cr_pending_r <= 1'b0;
      count_r      <= '0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      cr_pending_r <= cr_pending_nxt;
      count_r      <= count_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage. The main register refills whenever it is empty or being
  // taken, from the skid register first so that order is kept. A new result
  // that finds the main register stalled parks in the skid register, which
  // also closes in_tready until it drains.
  // --------------------------------------------------------------------------
  assign out_load = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid_r) begin
        out_byte_r   <= skid_byte_r;
        out_result_r <= skid_result_r;
      end else begin
        out_byte_r   <= in_tdata;
        out_result_r <= step_result;
      end
    end else if (in_fire) begin
      skid_byte_r   <= in_tdata;
      skid_result_r <= step_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_result_r.request_error, out_result_r.field_done,
                       out_result_r.role};
  assign out_tlast  = out_result_r.request_done;

endmodule

// File: rtl/core/hrht_step.sv
// ============================================================================
// hrht_step
// Next-state and byte classification logic of the tokenizer for one byte.
// ============================================================================
module hrht_step #(
  parameter int LIMIT_BITS = hrht_pkg::LIMIT_BITS_DEF
) (
  input  logic [7:0]                                   byte_i,
  input  hrht_pkg::phase_t                             phase_i,
  input  logic                                         cr_pending_i,
  input  logic [LIMIT_BITS:0]                          count_i,
  input  logic [hrht_pkg::NUM_LIMITS-1:0][LIMIT_BITS-1:0] limits_i,
  output hrht_pkg::phase_t                             phase_o,
  output logic                                         cr_pending_o,
  output logic [LIMIT_BITS:0]                          count_o,
  output hrht_pkg::result_t                            result_o
);
  import hrht_pkg::*;

  logic [LIMIT_BITS:0]   count_base;
  logic [LIMIT_BITS:0]   count_kept;
  logic [LIMIT_BITS-1:0] limit_sel;
  logic                  over;

  // A header line starts its name count from zero on the first name byte.
  assign count_base = (phase_i == PH_LINE) ? '0 : count_i;
  assign count_kept = count_base + {{LIMIT_BITS{1'b0}}, 1'b1};

  always_comb begin
    unique case (phase_i)
      PH_TARGET:          limit_sel = limits_i[REG_TARGET_LIMIT];
      PH_VERSION:         limit_sel = limits_i[REG_VERSION_LIMIT];
      PH_LINE, PH_NAME:   limit_sel = limits_i[REG_NAME_LIMIT];
      PH_VALUE:           limit_sel = limits_i[REG_VALUE_LIMIT];
      default:            limit_sel = limits_i[REG_METHOD_LIMIT];
    endcase
  end

  assign over = count_kept > {1'b0, limit_sel};

  always_comb begin
    phase_o      = phase_i;
    cr_pending_o = cr_pending_i;
    count_o      = count_i;
    result_o     = '{role: ROLE_DELIM, field_done: 1'b0, request_done: 1'b0,
                     request_error: 1'b0};
    unique case (phase_i)
      PH_LINE: begin
        if (byte_i == CH_CR) begin
          phase_o = PH_BLANK;
        end else if (byte_i == CH_SP) begin
          // One leading space of a header line is skipped.
          phase_o = PH_NAME;
          count_o = '0;
        end else if (byte_i == CH_COLON) begin
          result_o.field_done = 1'b1;
          phase_o      = PH_VALUE;
          count_o      = '0;
          cr_pending_o = 1'b0;
        end else begin
          phase_o                = PH_NAME;
          result_o.role          = ROLE_NAME;
          count_o                = count_kept;
          result_o.request_error = over;
        end
      end
      PH_BLANK: begin
        result_o.request_done  = (byte_i == CH_LF);
        result_o.request_error = (byte_i != CH_LF);
        phase_o      = PH_METHOD;
        cr_pending_o = 1'b0;
        count_o      = '0;
      end
      PH_TARGET: begin
        if (byte_i == CH_SP) begin
          result_o.field_done = 1'b1;
          phase_o      = PH_VERSION;
          count_o      = '0;
          cr_pending_o = 1'b0;
        end else begin
          result_o.role          = ROLE_TARGET;
          count_o                = count_kept;
          result_o.request_error = over;
        end
      end
      PH_VERSION, PH_VALUE: begin
        if (byte_i == CH_CR) begin
          cr_pending_o = 1'b1;
        end else if (byte_i == CH_LF && cr_pending_i) begin
          result_o.field_done = 1'b1;
          cr_pending_o = 1'b0;
          count_o      = '0;
          phase_o      = PH_LINE;
        end else begin
          cr_pending_o           = 1'b0;
          result_o.role          = (phase_i == PH_VERSION) ? ROLE_VERSION : ROLE_VALUE;
          count_o                = count_kept;
          result_o.request_error = over;
        end
      end
      PH_NAME: begin
        if (byte_i == CH_COLON) begin
          result_o.field_done = 1'b1;
          phase_o      = PH_VALUE;
          count_o      = '0;
          cr_pending_o = 1'b0;
        end else begin
          result_o.role          = ROLE_NAME;
          count_o                = count_kept;
          result_o.request_error = over;
        end
      end
      default: begin
        if (byte_i == CH_SP) begin
          result_o.field_done = 1'b1;
          phase_o = PH_TARGET;
          count_o = '0;
        end else begin
          phase_o                = PH_METHOD;
          result_o.role          = ROLE_METHOD;
          count_o                = count_kept;
          result_o.request_error = over;
        end
      end
    endcase

    // An error drops the request; the next byte begins a new one.
    if (result_o.request_error) begin
      phase_o      = PH_METHOD;
      cr_pending_o = 1'b0;
      count_o      = '0;
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the HTTP request head tokenizer core. Request heads,
// broken heads and raw noise are streamed byte by byte under several sets of
// field limits, and every result is checked against a cycle-free predictor.
// ============================================================================
module tb_top;
  import hrht_pkg::*;

  // --------------------------------------------------------------------------
  // Scoreboard: a software copy of the tokenizer state. Each accepted input
  // transaction is run through it at once, and the expected token is queued
  // until the matching output transaction shows up.
  // --------------------------------------------------------------------------
  class token_scoreboard;
    typedef struct {
      logic [7:0] data;
      role_t      role;
      logic       fdone;
      logic       rdone;
      logic       err;
    } token_t;

    logic [11:0] limits[NUM_LIMITS];
    phase_t      phase;
    logic        cr_pend;
    logic [12:0] fcount;
    token_t      expected_tokens[$];
    int          failures;
    int          checked;
    int          heads_done;
    int          errors_seen;

    function new();
      limits[REG_METHOD_LIMIT]  = 12'(METHOD_LIMIT_RST);
      limits[REG_TARGET_LIMIT]  = 12'(TARGET_LIMIT_RST);
      limits[REG_VERSION_LIMIT] = 12'(VERSION_LIMIT_RST);
      limits[REG_NAME_LIMIT]    = 12'(NAME_LIMIT_RST);
      limits[REG_VALUE_LIMIT]   = 12'(VALUE_LIMIT_RST);
      restart();
      failures = 0;
      checked = 0;
      heads_done = 0;
      errors_seen = 0;
    endfunction

    function void restart();
      phase = PH_METHOD;
      cr_pend = 1'b0;
      fcount = '0;
    endfunction

    // Unknown register indexes are ignored, and only the low limit bits count.
    function void set_limit(int idx, logic [31:0] value);
      if (idx < NUM_LIMITS) limits[idx] = value[11:0];
    endfunction

    // Counts one more byte in the current field; true once it runs past lim.
    function bit keep_byte(logic [11:0] lim);
      fcount = fcount + 13'd1;
      return fcount > {1'b0, lim};
    endfunction

    function void note_byte(logic [7:0] b);
      token_t t;
      phase_t ph;
      bit     consumed;
      t.data = b;
      t.role = ROLE_DELIM;
      t.fdone = 1'b0;
      t.rdone = 1'b0;
      t.err = 1'b0;
      ph = phase;
      consumed = 1'b0;
      // At a line start a CR may open the blank line, one space is skipped,
      // and anything else is already the first byte of a header name.
      if (ph == PH_LINE) begin
        if (b == CH_CR) begin
          phase = PH_BLANK;
          consumed = 1'b1;
        end else begin
          phase = PH_NAME;
          fcount = '0;
          if (b == CH_SP) consumed = 1'b1;
          else ph = PH_NAME;
        end
      end
      if (!consumed) begin
        case (ph)
          PH_BLANK: begin
            if (b == CH_LF) t.rdone = 1'b1;
            else t.err = 1'b1;
            restart();
          end
          PH_TARGET: begin
            if (b == CH_SP) begin
              t.fdone = 1'b1;
              phase = PH_VERSION;
              fcount = '0;
              cr_pend = 1'b0;
            end else begin
              t.role = ROLE_TARGET;
              if (keep_byte(limits[REG_TARGET_LIMIT])) t.err = 1'b1;
            end
          end
          PH_VERSION, PH_VALUE: begin
            if (b == CH_CR) begin
              cr_pend = 1'b1;
            end else if (b == CH_LF && cr_pend) begin
              t.fdone = 1'b1;
              cr_pend = 1'b0;
              fcount = '0;
              phase = PH_LINE;
            end else begin
              cr_pend = 1'b0;
              if (ph == PH_VERSION) begin
                t.role = ROLE_VERSION;
                if (keep_byte(limits[REG_VERSION_LIMIT])) t.err = 1'b1;
              end else begin
                t.role = ROLE_VALUE;
                if (keep_byte(limits[REG_VALUE_LIMIT])) t.err = 1'b1;
              end
            end
          end
          PH_NAME: begin
            if (b == CH_COLON) begin
              t.fdone = 1'b1;
              phase = PH_VALUE;
              fcount = '0;
              cr_pend = 1'b0;
            end else begin
              t.role = ROLE_NAME;
              if (keep_byte(limits[REG_NAME_LIMIT])) t.err = 1'b1;
            end
          end
          default: begin
            if (b == CH_SP) begin
              t.fdone = 1'b1;
              phase = PH_TARGET;
              fcount = '0;
            end else begin
              phase = PH_METHOD;
              t.role = ROLE_METHOD;
              if (keep_byte(limits[REG_METHOD_LIMIT])) t.err = 1'b1;
            end
          end
        endcase
      end
      if (t.err) restart();
      expected_tokens = {expected_tokens, t};
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function void check_token(logic [7:0] tdata, logic [4:0] tuser, logic tlast);
      token_t e;
      if (expected_tokens.size() == 0) begin
        report($sformatf("unexpected result tdata=%02h tuser=%02h tlast=%b",
                         tdata, tuser, tlast));
        return;
      end
      e = expected_tokens.pop_front();
      checked++;
      if (tdata !== e.data || tuser[2:0] !== e.role || tuser[3] !== e.fdone ||
          tuser[4] !== e.err || tlast !== e.rdone)
        report($sformatf({"token %0d: expected byte=%02h role=%0d fdone=%b err=%b done=%b,",
                          " got byte=%02h role=%0d fdone=%b err=%b done=%b"},
                         checked, e.data, e.role, e.fdone, e.err, e.rdone, tdata,
                         tuser[2:0], tuser[3], tuser[4], tlast));
      if (e.rdone) heads_done++;
      if (e.err) errors_seen++;
    endfunction

    function void finish_check();
      if (expected_tokens.size() != 0)
        report($sformatf("%0d tokens never arrived", expected_tokens.size()));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals.
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [7:0] out_byte
  logic [4:0]  out_tuser;   // [2:0] role, [3] field_done, [4] request_error
  logic        out_tlast;   // request_done
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  http_request_head_tokenizer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  token_scoreboard sb;
  logic [7:0]      tx_bytes[$];    // bytes waiting to be offered to the DUT
  int              burst_left;     // sender transactions left without gaps
  int              hold_request;   // long receiver hold-off asked by the main flow
  int              settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: the slowest legal run is far shorter than this.
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Random helpers for the byte stream.
  // --------------------------------------------------------------------------

  // Appends one byte to the send queue.
  function void queue_byte(logic [7:0] b);
    tx_bytes = {tx_bytes, b};
  endfunction

  // Sender gap before the next transaction: mostly none, sometimes short,
  // rarely long, with occasional stretches of back-to-back traffic.
  function int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Mostly printable text, now and then any byte; the one delimiter that
  // would end the field early is replaced.
  function logic [7:0] pick_text(logic [7:0] avoid);
    logic [7:0] r;
    if ($urandom_range(0, 7) == 0) r = 8'($urandom_range(0, 255));
    else r = 8'($urandom_range(8'h21, 8'h7E));
    if (r == avoid) r = 8'h61;
    return r;
  endfunction

  // Field lengths stay short, but with a small limit the field is sometimes
  // made exactly as long as allowed or one byte too long.
  function int pick_len(int lim);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (lim <= 40 && r == 1) return lim;
    if (lim <= 40 && r == 2) return lim + 1;
    return $urandom_range(1, 6);
  endfunction

  function void push_field(int n, logic [7:0] avoid);
    for (int i = 0; i < n; i++) queue_byte(pick_text(avoid));
  endfunction

  // One request head with random content. A broken head ends with a CR that
  // is not followed by LF.
  function void push_request(bit broken);
    int nh;
    push_field(pick_len(int'(sb.limits[REG_METHOD_LIMIT])), CH_SP);
    queue_byte(CH_SP);
    push_field(pick_len(int'(sb.limits[REG_TARGET_LIMIT])), CH_SP);
    queue_byte(CH_SP);
    push_field(pick_len(int'(sb.limits[REG_VERSION_LIMIT])), CH_CR);
    queue_byte(CH_CR);
    queue_byte(CH_LF);
    nh = $urandom_range(0, 4);
    for (int h = 0; h < nh; h++) begin
      if ($urandom_range(0, 3) == 0) queue_byte(CH_SP);
      push_field(pick_len(int'(sb.limits[REG_NAME_LIMIT])), CH_COLON);
      queue_byte(CH_COLON);
      push_field(pick_len(int'(sb.limits[REG_VALUE_LIMIT])), CH_CR);
      // A CR inside the value that is not followed by LF stays in the value.
      if ($urandom_range(0, 5) == 0) begin
        queue_byte(CH_CR);
        queue_byte(pick_text(CH_LF));
      end
      if ($urandom_range(0, 5) == 0) queue_byte(CH_CR);
      queue_byte(CH_CR);
      queue_byte(CH_LF);
    end
    queue_byte(CH_CR);
    if (broken) queue_byte(pick_text(CH_LF));
    else queue_byte(CH_LF);
  endfunction

  function void build_traffic(int count);
    int r;
    tx_bytes.delete();
    while (tx_bytes.size() < count) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        for (int i = $urandom_range(1, 12); i > 0; i--)
          queue_byte(8'($urandom_range(0, 255)));
      end else begin
        push_request(r == 1);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver tasks. All are entered right after a rising edge.
  // --------------------------------------------------------------------------

  // One APB write: setup cycle, then access cycle until pready.
  task automatic write_limit(int idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_limit(idx, value);
  endtask

  task automatic write_all_limits(logic [31:0] m, logic [31:0] t, logic [31:0] v,
                                  logic [31:0] n, logic [31:0] h);
    write_limit(int'(REG_METHOD_LIMIT), m);
    write_limit(int'(REG_TARGET_LIMIT), t);
    write_limit(int'(REG_VERSION_LIMIT), v);
    write_limit(int'(REG_NAME_LIMIT), n);
    write_limit(int'(REG_VALUE_LIMIT), h);
    settings_used++;
  endtask

  // Offers every queued byte in order. tvalid is only lowered when a gap
  // follows, so back-to-back transactions keep it high.
  task automatic send_bytes();
    int gap;
    for (int i = 0; i < tx_bytes.size(); i++) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= tx_bytes[i];
      do @(posedge clk); while (!in_tready);
      sb.note_byte(tx_bytes[i]);
    end
    in_tvalid <= 1'b0;
  endtask

  // Every byte yields one token, so an empty queue means nothing is in flight;
  // the extra cycles cover the output stage.
  task automatic wait_drained();
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, runs of steady acceptance, and long hold-offs
  // when the main flow asks for one, so the DUT fills and stops its input.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    int run_left;
    int r;
    stall_left = 0;
    run_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        run_left = $urandom_range(0, 20);
        if (r < 60) stall_left = 0;
        else if (r < 85) stall_left = $urandom_range(1, 3);
        else if (r < 97) stall_left = $urandom_range(4, 12);
        else stall_left = $urandom_range(20, 60);
        out_tready <= (stall_left == 0);
      end
    end
  end

  // Output monitor: a token counts at an edge where tvalid and tready are high.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_token(out_tdata, out_tuser, out_tlast);
  end

  // --------------------------------------------------------------------------
  // Main flow.
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    burst_left = 0;
    hold_request = 0;
    settings_used = 1;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed head under the reset limits: a lone LF kept in the version,
    // repeated CRs before the line end, a skipped line-start space followed
    // by a space and a CR inside the name, a 0xFF value, an empty name opened
    // by a line-start colon, and the blank line that completes the head.
    tx_bytes = '{8'h47, CH_SP, 8'h2F, CH_SP, 8'h48, CH_LF, CH_CR, CH_CR, CH_LF,
                 CH_SP, CH_SP, CH_CR, CH_COLON, 8'hFF, CH_CR, CH_LF,
                 CH_COLON, CH_CR, CH_LF, CH_CR, CH_LF};
    send_bytes();
    wait_drained();

    // A method limit of one: the second method byte overflows. Then an empty
    // method and target lead to a blank line whose CR is followed by junk.
    write_limit(int'(REG_METHOD_LIMIT), 32'd1);
    settings_used++;
    tx_bytes = '{8'h00, 8'hFF, CH_SP, CH_SP, CH_CR, CH_LF, CH_CR, 8'h78};
    send_bytes();
    wait_drained();

    // Largest limits, written with every upper bit set; writes to the unused
    // register addresses must leave the limits alone.
    write_all_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
    write_limit(NUM_LIMITS, $urandom());
    write_limit(7, $urandom());
    build_traffic(100);
    send_bytes();
    wait_drained();

    // Smallest limits: nearly every field overflows at its second byte.
    write_all_limits(32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
    build_traffic(70);
    send_bytes();
    wait_drained();

    // Small random limits, with a long receiver hold-off at the start while
    // the sender keeps offering bytes.
    write_all_limits($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
                     $urandom_range(1, 12), $urandom_range(1, 12));
    build_traffic(120);
    hold_request = 300;
    send_bytes();
    wait_drained();

    // Mixed limits over the whole range, a few of them small.
    write_all_limits($urandom_range(1, 8), $urandom_range(1, 4095), $urandom_range(1, 8),
                     $urandom_range(1, 4095), $urandom_range(1, 8));
    build_traffic(110);
    send_bytes();
    wait_drained();

    sb.finish_check();
    $display("Checked %0d tokens under %0d limit settings: %0d heads completed,",
             sb.checked, settings_used, sb.heads_done);
    $display("%0d error tokens, %0d mismatches.", sb.errors_seen, sb.failures);
    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
